// ----- rtl/zbtr_pkg.sv -----
package zbtr_pkg;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_TRI    = 2'd1,
        KIND_READ   = 2'd2,
        KIND_HIDDEN = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] vert_a_row;
        logic signed [15:0] vert_a_col;
        logic signed [15:0] vert_b_row;
        logic signed [15:0] vert_b_col;
        logic signed [15:0] vert_c_row;
        logic signed [15:0] vert_c_col;
        logic signed [23:0] depth_a;
        logic signed [23:0] depth_b;
        logic signed [23:0] depth_c;
        logic [15:0]        triangle_id;
        logic [15:0]        pixel_index;
    } req_t;

    typedef struct packed {
        logic [15:0] pixel_triangle;
        logic        covered;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SETUP,
        ST_SETUP2,
        ST_DEN,
        ST_CHECK,
        ST_PIX,
        ST_PIX2,
        ST_RMW,
        ST_READ,
        ST_READ2
    } state_t;

endpackage

// ----- rtl/zbuffer_triangle_rasterizer.sv -----
// latency: read result strobe two cycles after the accepting edge, busy for 2 cycles
// clear: busy for IMG_SIZE^2 cycles after the accepting edge, one pixel per cycle
// triangle: busy for 4 setup cycles plus 3 per pixel of the bounding box, 4 if dropped,
// one pixel in flight through the read-modify-write of the pixel memory
// reset: an init pass of IMG_SIZE^2 cycles clears the valid memory, busy high meanwhile
// results are strobed for one cycle; the receiver cannot stall
module zbuffer_triangle_rasterizer #(
    parameter int IMG_SIZE  = 224,
    parameter int FRAC_BITS = 6,
    parameter int ID_BITS   = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  zbtr_pkg::req_t req,
    output logic           rsp_valid,
    output zbtr_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata
);

    localparam int NPIX = IMG_SIZE * IMG_SIZE;
    localparam int AW   = $clog2(NPIX);
    localparam int CW   = 17;

    zbtr_pkg::state_t state_reg, state_next;

    logic [ID_BITS-1:0] id_mem [NPIX];
    logic [25:0]        dep_mem [NPIX];
    logic               val_mem [NPIX];

    logic [15:0]        bg_reg;
    zbtr_pkg::req_t     rq_reg;
    logic [AW-1:0]      cnt_reg;
    logic signed [CW-1:0] umin_reg, umax_reg, vmin_reg, vmax_reg, u_reg, v_reg;
    logic signed [16:0] e0r_reg, e0c_reg, e1r_reg, e1c_reg;
    logic signed [33:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [34:0] den_reg;
    logic               neg_reg;
    logic signed [25:0] z_reg;
    logic signed [17:0] pr_reg, pc_reg;
    logic [AW-1:0]      addr_reg;

    logic [ID_BITS-1:0] id_rd;
    logic [25:0]        dep_rd;
    logic               val_rd;
    logic               rsp_valid_reg;
    zbtr_pkg::rsp_t     rsp_reg;
    logic               oor_reg;

    function automatic logic signed [CW-1:0] fl(input logic signed [15:0] x);
        logic signed [15:0] s;
        s = x >>> FRAC_BITS;
        return CW'(s);
    endfunction

    function automatic logic signed [CW-1:0] cl(input logic signed [15:0] x);
        logic signed [16:0] n;
        logic signed [16:0] s;
        n = -17'(x);
        s = n >>> FRAC_BITS;
        return CW'(-s);
    endfunction

    function automatic logic signed [15:0] mn3(input logic signed [15:0] a, b, c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [15:0] mx3(input logic signed [15:0] a, b, c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic accept;
    assign accept = start && !busy;

    logic mem_we_clr, mem_we_pix;
    logic [AW-1:0] rd_addr;
    logic signed [35:0] a_val, b_val;
    logic signed [36:0] ab_val;
    logic signed [35:0] den_abs;
    logic pix_hit;
    logic win;

    assign den_abs = neg_reg ? -36'(den_reg) : 36'(den_reg);
    assign a_val = neg_reg ? -(36'(p1_reg) - 36'(p2_reg)) : (36'(p1_reg) - 36'(p2_reg));
    assign b_val = neg_reg ? -(36'(p3_reg) - 36'(p4_reg)) : (36'(p3_reg) - 36'(p4_reg));
    assign ab_val = 37'(a_val) + 37'(b_val);
    assign pix_hit = (den_reg == '0) || (a_val >= 0 && a_val <= den_abs && b_val >= 0
                     && b_val <= den_abs && ab_val <= 37'(den_abs));
    // hit is evaluated in the cycle the memory read returns
    assign win = pix_hit && (!val_rd || $signed(dep_rd) < z_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            zbtr_pkg::ST_INIT:
                if (cnt_reg == AW'(NPIX - 1)) state_next = zbtr_pkg::ST_IDLE;
            zbtr_pkg::ST_IDLE:
                if (start)
                begin
                    unique case (zbtr_pkg::kind_t'(req.kind))
                        zbtr_pkg::KIND_CLEAR:  state_next = zbtr_pkg::ST_CLEAR;
                        zbtr_pkg::KIND_TRI:    state_next = zbtr_pkg::ST_SETUP;
                        zbtr_pkg::KIND_READ:   state_next = zbtr_pkg::ST_READ;
                        zbtr_pkg::KIND_HIDDEN: state_next = zbtr_pkg::ST_IDLE;
                    endcase
                end
            zbtr_pkg::ST_CLEAR:
                if (cnt_reg == AW'(NPIX - 1)) state_next = zbtr_pkg::ST_IDLE;
            zbtr_pkg::ST_SETUP:  state_next = zbtr_pkg::ST_SETUP2;
            zbtr_pkg::ST_SETUP2: state_next = zbtr_pkg::ST_DEN;
            zbtr_pkg::ST_DEN:    state_next = zbtr_pkg::ST_CHECK;
            zbtr_pkg::ST_CHECK:
                if (umin_reg < 0 || vmin_reg < 0 || umax_reg >= CW'(IMG_SIZE)
                    || vmax_reg >= CW'(IMG_SIZE) || umin_reg > umax_reg
                    || vmin_reg > vmax_reg)
                    state_next = zbtr_pkg::ST_IDLE;
                else
                    state_next = zbtr_pkg::ST_PIX;
            zbtr_pkg::ST_PIX:  state_next = zbtr_pkg::ST_PIX2;
            zbtr_pkg::ST_PIX2: state_next = zbtr_pkg::ST_RMW;
            zbtr_pkg::ST_RMW:
                if (u_reg == umax_reg && v_reg == vmax_reg)
                    state_next = zbtr_pkg::ST_IDLE;
                else
                    state_next = zbtr_pkg::ST_PIX;
            zbtr_pkg::ST_READ:  state_next = zbtr_pkg::ST_READ2;
            zbtr_pkg::ST_READ2: state_next = zbtr_pkg::ST_IDLE;
            default:            state_next = zbtr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = (state_reg != zbtr_pkg::ST_IDLE);
        mem_we_clr = (state_reg == zbtr_pkg::ST_CLEAR) || (state_reg == zbtr_pkg::ST_INIT);
        mem_we_pix = (state_reg == zbtr_pkg::ST_RMW) && win;
        rd_addr    = addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= zbtr_pkg::ST_INIT;
            cnt_reg       <= '0;
            bg_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= (state_reg == zbtr_pkg::ST_READ2);
            if (cfg_we) bg_reg <= cfg_wdata;
            if (mem_we_clr)
                cnt_reg <= (cnt_reg == AW'(NPIX - 1)) ? '0 : cnt_reg + 1'b1;
        end
    end

    // pixel memories, one read port, one write port
    always_ff @(posedge clk)
    begin
        if (mem_we_clr)
        begin
            val_mem[cnt_reg] <= 1'b0;
            if (state_reg == zbtr_pkg::ST_CLEAR) id_mem[cnt_reg] <= ID_BITS'(bg_reg);
        end
        else if (mem_we_pix)
        begin
            val_mem[addr_reg] <= 1'b1;
            id_mem[addr_reg]  <= ID_BITS'(rq_reg.triangle_id);
            dep_mem[addr_reg] <= 26'(z_reg);
        end
        id_rd  <= id_mem[rd_addr];
        dep_rd <= dep_mem[rd_addr];
        val_rd <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept) rq_reg <= req;
        unique case (state_reg)
            zbtr_pkg::ST_IDLE:
                if (accept)
                begin
                    oor_reg  <= (32'(req.pixel_index) >= 32'(NPIX));
                    addr_reg <= (32'(req.pixel_index) >= 32'(NPIX)) ? '0
                                : AW'(req.pixel_index);
                end
            zbtr_pkg::ST_SETUP:
            begin
                umin_reg <= cl(mn3(rq_reg.vert_a_row, rq_reg.vert_b_row, rq_reg.vert_c_row));
                umax_reg <= fl(mx3(rq_reg.vert_a_row, rq_reg.vert_b_row, rq_reg.vert_c_row));
                vmin_reg <= cl(mn3(rq_reg.vert_a_col, rq_reg.vert_b_col, rq_reg.vert_c_col));
                vmax_reg <= fl(mx3(rq_reg.vert_a_col, rq_reg.vert_b_col, rq_reg.vert_c_col));
                e0r_reg  <= 17'(rq_reg.vert_c_row) - 17'(rq_reg.vert_a_row);
                e0c_reg  <= 17'(rq_reg.vert_c_col) - 17'(rq_reg.vert_a_col);
                e1r_reg  <= 17'(rq_reg.vert_b_row) - 17'(rq_reg.vert_a_row);
                e1c_reg  <= 17'(rq_reg.vert_b_col) - 17'(rq_reg.vert_a_col);
                z_reg    <= 26'(rq_reg.depth_a) + 26'(rq_reg.depth_b) + 26'(rq_reg.depth_c);
            end
            zbtr_pkg::ST_SETUP2:
            begin
                p1_reg <= e1r_reg * e0c_reg;
                p2_reg <= e1c_reg * e0r_reg;
                u_reg  <= umin_reg;
                v_reg  <= vmin_reg;
            end
            zbtr_pkg::ST_DEN:
            begin
                den_reg <= 35'(p1_reg) - 35'(p2_reg);
                neg_reg <= (35'(p1_reg) - 35'(p2_reg)) < 0;
            end
            zbtr_pkg::ST_PIX:
            begin
                pr_reg   <= 18'((32'(u_reg) <<< FRAC_BITS) - 32'(rq_reg.vert_a_row));
                pc_reg   <= 18'((32'(v_reg) <<< FRAC_BITS) - 32'(rq_reg.vert_a_col));
                addr_reg <= AW'(32'(u_reg) * IMG_SIZE + 32'(v_reg));
            end
            zbtr_pkg::ST_PIX2:
            begin
                p1_reg <= 34'(e1r_reg * pc_reg);
                p2_reg <= 34'(e1c_reg * pr_reg);
                p3_reg <= 34'(pr_reg * e0c_reg);
                p4_reg <= 34'(pc_reg * e0r_reg);
            end
            zbtr_pkg::ST_RMW:
            begin
                if (v_reg == vmax_reg)
                begin
                    v_reg <= vmin_reg;
                    u_reg <= u_reg + 1'b1;
                end
                else
                    v_reg <= v_reg + 1'b1;
            end
            zbtr_pkg::ST_READ2:
            begin
                rsp_reg.pixel_triangle <= oor_reg ? bg_reg : 16'(id_rd);
                rsp_reg.covered        <= oor_reg ? 1'b0 : val_rd;
            end
            default: ;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_rsp_only_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $past(state_reg) == zbtr_pkg::ST_READ2)
        else $error("result without read");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == zbtr_pkg::ST_RMW) |-> busy)
        else $error("idle during pixel update");
    a_rsp_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |=> !rsp_valid)
        else $error("result repeated");

endmodule
